// ===== sv/jdta_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jdta_pkg
// Shared types, message codes and constants for the joystick direction
// classifier with temperature alarm.
// ----------------------------------------------------------------------------
package jdta_pkg;

    localparam int ADC_BITS   = 12;
    localparam int DEB_BITS   = 16;
    localparam int TIME_BITS  = 32;
    localparam int MSG_BITS   = 4;
    localparam int KIND_BITS  = 2;
    localparam int CIDX_BITS  = 3;
    localparam int CDATA_BITS = 16;
    localparam int IN_BITS    = 3 * ADC_BITS + TIME_BITS;
    localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = MSG_BITS + 1;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef logic [ADC_BITS-1:0]  adc_t;
    typedef logic [TIME_BITS-1:0] ms_t;
    typedef logic [MSG_BITS-1:0]  msg_t;
    typedef logic [KIND_BITS-1:0] kind_t;

    localparam kind_t KIND_SAMPLE = 2'd0;
    localparam kind_t KIND_ACK    = 2'd1;
    localparam kind_t KIND_TOGGLE = 2'd2;

    localparam msg_t MSG_HOLD       = 4'd0;
    localparam msg_t MSG_UP         = 4'd1;
    localparam msg_t MSG_DOWN       = 4'd2;
    localparam msg_t MSG_LEFT       = 4'd3;
    localparam msg_t MSG_RIGHT      = 4'd4;
    localparam msg_t MSG_UP_LEFT    = 4'd5;
    localparam msg_t MSG_UP_RIGHT   = 4'd6;
    localparam msg_t MSG_DOWN_LEFT  = 4'd7;
    localparam msg_t MSG_DOWN_RIGHT = 4'd8;
    localparam msg_t MSG_ALARM      = 4'd9;
    localparam msg_t MSG_ALARM_ACK  = 4'd10;
    localparam msg_t MSG_NORMAL     = 4'd11;
    localparam msg_t MSG_INVERSION  = 4'd12;

    localparam logic [CIDX_BITS-1:0] REG_AXIS_LOW    = 3'd0;
    localparam logic [CIDX_BITS-1:0] REG_AXIS_HIGH   = 3'd1;
    localparam logic [CIDX_BITS-1:0] REG_ALARM_ABOVE = 3'd2;
    localparam logic [CIDX_BITS-1:0] REG_RELEASE_BLW = 3'd3;
    localparam logic [CIDX_BITS-1:0] REG_DEBOUNCE    = 3'd4;

    localparam adc_t RST_AXIS_LOW    = ADC_BITS'(1500);
    localparam adc_t RST_AXIS_HIGH   = ADC_BITS'(2500);
    localparam adc_t RST_ALARM_ABOVE = ADC_BITS'(958);
    localparam adc_t RST_RELEASE_BLW = ADC_BITS'(953);
    localparam logic [DEB_BITS-1:0] RST_DEBOUNCE = DEB_BITS'(250);

    typedef struct packed {
        adc_t                axis_low;
        adc_t                axis_high;
        adc_t                alarm_above;
        adc_t                release_below;
        logic [DEB_BITS-1:0] debounce_ms;
    } cfg_t;

    typedef struct packed {
        kind_t mode;
        adc_t  x_code;
        adc_t  y_code;
        adc_t  temp_code;
        ms_t   now_ms;
    } item_t;

    typedef struct packed {
        logic has_result;
        msg_t message_code;
        logic inverted;
    } result_t;

    function automatic msg_t mirror_dir(input msg_t dir);
        msg_t m;
        begin
            case (dir)
                MSG_UP:         m = MSG_DOWN;
                MSG_DOWN:       m = MSG_UP;
                MSG_LEFT:       m = MSG_RIGHT;
                MSG_RIGHT:      m = MSG_LEFT;
                MSG_UP_LEFT:    m = MSG_DOWN_RIGHT;
                MSG_UP_RIGHT:   m = MSG_DOWN_LEFT;
                MSG_DOWN_LEFT:  m = MSG_UP_RIGHT;
                MSG_DOWN_RIGHT: m = MSG_UP_LEFT;
                default:        m = MSG_HOLD;
            endcase
            return m;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/jdta_classify.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jdta_classify
// Direction classifier: strict low/high threshold compares on X and Y,
// optional point reflection through the center.
// ----------------------------------------------------------------------------
module jdta_classify (
    input  wire jdta_pkg::adc_t x_code,
    input  wire jdta_pkg::adc_t y_code,
    input  wire jdta_pkg::adc_t axis_low,
    input  wire jdta_pkg::adc_t axis_high,
    input  wire                 invert,
    output jdta_pkg::msg_t      dir
);

    logic x_hi, x_lo, x_mid, y_hi, y_lo, y_mid;
    jdta_pkg::msg_t raw;

    assign x_hi  = x_code > axis_high;
    assign x_lo  = x_code < axis_low;
    assign x_mid = (x_code > axis_low) && (x_code < axis_high);
    assign y_hi  = y_code > axis_high;
    assign y_lo  = y_code < axis_low;
    assign y_mid = (y_code > axis_low) && (y_code < axis_high);

    always_comb begin
        if (x_hi && y_mid) begin
            raw = jdta_pkg::MSG_RIGHT;
        end else if (x_hi && y_hi) begin
            raw = jdta_pkg::MSG_DOWN_RIGHT;
        end else if (x_hi && y_lo) begin
            raw = jdta_pkg::MSG_UP_RIGHT;
        end else if (x_lo && y_mid) begin
            raw = jdta_pkg::MSG_LEFT;
        end else if (x_lo && y_hi) begin
            raw = jdta_pkg::MSG_DOWN_LEFT;
        end else if (x_lo && y_lo) begin
            raw = jdta_pkg::MSG_UP_LEFT;
        end else if (x_mid && y_lo) begin
            raw = jdta_pkg::MSG_UP;
        end else if (x_mid && y_hi) begin
            raw = jdta_pkg::MSG_DOWN;
        end else begin
            raw = jdta_pkg::MSG_HOLD;
        end
    end

    assign dir = invert ? jdta_pkg::mirror_dir(raw) : raw;

endmodule
`default_nettype wire

// ===== sv/jdta_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jdta_core
// Alarm, acknowledge and inversion state with the per-word decision logic.
// State advances on each word taken from the input register.
// ----------------------------------------------------------------------------
module jdta_core (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    advance,
    input  wire jdta_pkg::item_t   item,
    input  wire jdta_pkg::cfg_t    cfg,
    output jdta_pkg::result_t      res
);

    logic over_limit_reg, over_limit_next;
    logic alarm_acked_reg, alarm_acked_next;
    logic inversion_reg, inversion_next;
    jdta_pkg::ms_t last_toggle_reg, last_toggle_next;

    jdta_pkg::msg_t dir;
    jdta_pkg::ms_t  elapsed;
    logic           over_now;

    jdta_classify u_classify (
        .x_code    (item.x_code),
        .y_code    (item.y_code),
        .axis_low  (cfg.axis_low),
        .axis_high (cfg.axis_high),
        .invert    (inversion_reg),
        .dir       (dir)
    );

    assign over_now = item.temp_code > cfg.alarm_above;
    assign elapsed  = item.now_ms - last_toggle_reg;

    always_comb begin
        over_limit_next  = over_limit_reg;
        alarm_acked_next = alarm_acked_reg;
        inversion_next   = inversion_reg;
        last_toggle_next = last_toggle_reg;
        res.has_result   = 1'b0;
        res.message_code = jdta_pkg::MSG_HOLD;
        case (item.mode)
            jdta_pkg::KIND_SAMPLE: begin
                over_limit_next = over_now;
                res.has_result  = 1'b1;
                if (over_now && !alarm_acked_reg) begin
                    res.message_code = jdta_pkg::MSG_ALARM;
                end else begin
                    res.message_code = dir;
                end
                if (alarm_acked_reg && (item.temp_code < cfg.release_below)) begin
                    alarm_acked_next = 1'b0;
                end
            end
            jdta_pkg::KIND_ACK: begin
                if (over_limit_reg && !alarm_acked_reg) begin
                    alarm_acked_next = 1'b1;
                    res.has_result   = 1'b1;
                    res.message_code = jdta_pkg::MSG_ALARM_ACK;
                end
            end
            jdta_pkg::KIND_TOGGLE: begin
                if (!(over_limit_reg && !alarm_acked_reg) &&
                    (elapsed > {{(jdta_pkg::TIME_BITS-jdta_pkg::DEB_BITS){1'b0}},
                                cfg.debounce_ms})) begin
                    last_toggle_next = item.now_ms;
                    inversion_next   = !inversion_reg;
                    res.has_result   = 1'b1;
                    res.message_code = inversion_reg ? jdta_pkg::MSG_NORMAL
                                                     : jdta_pkg::MSG_INVERSION;
                end
            end
            default: begin
            end
        endcase
        res.inverted = inversion_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            over_limit_reg  <= 1'b0;
            alarm_acked_reg <= 1'b0;
            inversion_reg   <= 1'b0;
            last_toggle_reg <= '0;
        end else if (advance) begin
            over_limit_reg  <= over_limit_next;
            alarm_acked_reg <= alarm_acked_next;
            inversion_reg   <= inversion_next;
            last_toggle_reg <= last_toggle_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/joystick_direction_with_temp_alarm.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// joystick_direction_with_temp_alarm
// Pipeline: the accepted input word is held in the input register, then its
//   result goes to the result register, which drives m_tvalid and m_tdata.
// Throughput: one word per cycle unless the output stalls, result or not.
// Reset (aresetn low, synchronous): pipeline emptied, alarm, acknowledge and
//   inversion flags cleared, thresholds back to their defaults.
// ----------------------------------------------------------------------------
module joystick_direction_with_temp_alarm (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // x_code[11:0], y_code[23:12], temp_code[35:24], now_ms[67:36], zero pad
    input  wire [jdta_pkg::IN_TDATA_W-1:0]      s_tdata,
    // mode[1:0]
    input  wire [jdta_pkg::KIND_BITS-1:0]       s_tuser,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // message_code[3:0], inverted[4], zero pad
    output logic [jdta_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire [jdta_pkg::CIDX_BITS-1:0]       cfg_index,
    input  wire [jdta_pkg::CDATA_BITS-1:0]      cfg_data
);

    localparam int AB = jdta_pkg::ADC_BITS;

    jdta_pkg::cfg_t    cfg_reg;
    jdta_pkg::item_t   item_reg;
    logic              in_valid_reg;
    jdta_pkg::result_t res;
    logic              out_valid_reg;
    jdta_pkg::msg_t    out_msg_reg;
    logic              out_inv_reg;
    logic              advance;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.axis_low      <= jdta_pkg::RST_AXIS_LOW;
            cfg_reg.axis_high     <= jdta_pkg::RST_AXIS_HIGH;
            cfg_reg.alarm_above   <= jdta_pkg::RST_ALARM_ABOVE;
            cfg_reg.release_below <= jdta_pkg::RST_RELEASE_BLW;
            cfg_reg.debounce_ms   <= jdta_pkg::RST_DEBOUNCE;
        end else if (cfg_valid) begin
            case (cfg_index)
                jdta_pkg::REG_AXIS_LOW:    cfg_reg.axis_low      <= cfg_data[AB-1:0];
                jdta_pkg::REG_AXIS_HIGH:   cfg_reg.axis_high     <= cfg_data[AB-1:0];
                jdta_pkg::REG_ALARM_ABOVE: cfg_reg.alarm_above   <= cfg_data[AB-1:0];
                jdta_pkg::REG_RELEASE_BLW: cfg_reg.release_below <= cfg_data[AB-1:0];
                jdta_pkg::REG_DEBOUNCE:    cfg_reg.debounce_ms   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.mode      <= s_tuser;
            item_reg.x_code    <= s_tdata[AB-1:0];
            item_reg.y_code    <= s_tdata[2*AB-1:AB];
            item_reg.temp_code <= s_tdata[3*AB-1:2*AB];
            item_reg.now_ms    <= s_tdata[jdta_pkg::IN_BITS-1:3*AB];
        end
    end

    jdta_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= res.has_result;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res.has_result) begin
            out_msg_reg <= res.message_code;
            out_inv_reg <= res.inverted;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(jdta_pkg::OUT_TDATA_W-jdta_pkg::OUT_BITS){1'b0}},
                       out_inv_reg, out_msg_reg};

endmodule
`default_nettype wire
